>>> hw/rtl/bbc_pkg.sv
// Shared types and codes for the buffer cache controller.
package bbc_pkg;

    localparam int NUM_BUFFERS = 16;
    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 3;
    localparam int INDEX_BITS  = 4;

    localparam logic [OP_BITS-1:0] OP_GET     = 3'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_BITS-1:0] OP_DELAYED = 3'd2;
    localparam logic [OP_BITS-1:0] OP_WRITE   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_FLUSH   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_HIT       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FILL      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_RETRY     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NO_FREE   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_WRITEBACK = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_DONE      = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_BAD       = 3'd6;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;       // capture the incoming transaction
        logic scan_start; // begin a tag or delayed-write scan
        logic scan_step;  // advance the scan by one entry
        logic do_remove;  // unlink target from free list
        logic do_append;  // link target at free-list tail
        logic set_busy;
        logic clr_busy;
        logic set_dw;
        logic clr_dw;
        logic set_tag;    // write tag, set valid
        logic tgt_head;   // target := free head
        logic tgt_scan;   // target := scan pointer
        logic tgt_idx;    // target := buffer_index
    } bbc_cmd_t;

    // Datapath status returned to the controller.
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               scan_done;
        logic               scan_hit;
        logic               tgt_busy;
        logic               tgt_dw;
        logic               idx_ok;
        logic               list_empty;
    } bbc_stat_t;

endpackage

>>> hw/rtl/block_buffer_cache_lru.sv
// Top level of the block buffer cache controller with LRU free list.
// One transaction at a time: an operation is taken, then its results go out
// one per output transaction, the final one with last set. A get scans the
// tag entries in index order up to the hit entry; a miss scans all sixteen
// entries, then writes back each delayed-write entry met at the free-list
// head before it takes the head. An output stall holds the result in the
// output stage. Flush walks the free list one entry per cycle from the head
// and restarts the walk after each writeback. The walks are sequential
// because tags and links sit in the datapath and are visited one entry per
// cycle. No clearing pass follows reset; the block is ready on the first
// cycle after reset is released.
// Index and block fields read zero for retry, no-free, done and bad results.
module block_buffer_cache_lru #(
    parameter int BLOCK_BITS  = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [23:0] block_number,
    input  logic [3:0]  buffer_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  entry_index,
    output logic [23:0] entry_block,
    output logic        last
);
    bbc_pkg::bbc_cmd_t  cmd;
    bbc_pkg::bbc_stat_t stat;
    logic               scan_tag_mode;
    logic               use_tgt;
    logic [3:0]         tgt_index;
    logic [23:0]        tgt_block;

    bbc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_status    (status),
        .out_use_tgt   (use_tgt),
        .out_last      (last),
        .cmd           (cmd),
        .scan_tag_mode (scan_tag_mode),
        .stat          (stat)
    );

    bbc_datapath #(
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .scan_tag_mode (scan_tag_mode),
        .in_op         (op),
        .in_block      (block_number),
        .in_index      (buffer_index),
        .stat          (stat),
        .tgt_index     (tgt_index),
        .tgt_block     (tgt_block)
    );

    // Target fields hold steady while the result waits in the output stage.
    assign entry_index = use_tgt ? tgt_index : 4'd0;
    assign entry_block = use_tgt ? tgt_block : 24'd0;
endmodule

>>> hw/rtl/bbc_datapath.sv
// Datapath: tags, marks, doubly linked free list and scan pointer.
module bbc_datapath #(
    parameter int BLOCK_BITS  = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bbc_pkg::bbc_cmd_t           cmd,
    input  logic                        scan_tag_mode,
    input  logic [bbc_pkg::OP_BITS-1:0] in_op,
    input  logic [23:0]                 in_block,
    input  logic [3:0]                  in_index,
    output bbc_pkg::bbc_stat_t          stat,
    output logic [3:0]                  tgt_index,
    output logic [23:0]                 tgt_block
);
    localparam int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS;
    localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CW = $clog2(NUM_BUFFERS + 1);
    localparam int BW = (BLOCK_BITS < 24) ? BLOCK_BITS : 24;

    logic [BW-1:0]          tag_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] valid_reg, busy_reg, dw_reg;
    logic [IW-1:0]          nxt_reg [NUM_BUFFERS];
    logic [IW-1:0]          prv_reg [NUM_BUFFERS];
    logic [IW-1:0]          head_reg, tail_reg;
    logic [CW-1:0]          count_reg;

    logic [bbc_pkg::OP_BITS-1:0] op_reg;
    logic [BW-1:0]               blk_reg;
    logic [3:0]                  idx_reg;
    logic [IW-1:0]               tgt_reg, scan_reg;
    logic [CW-1:0]               left_reg;

    logic [IW-1:0] tgt_next;
    logic          idx_ok;

    assign idx_ok = ({1'b0, idx_reg} < 5'(NUM_BUFFERS));

    always_comb
    begin
        tgt_next = tgt_reg;
        if (cmd.tgt_head)
        begin
            tgt_next = head_reg;
        end
        else if (cmd.tgt_scan)
        begin
            tgt_next = scan_reg;
        end
        else if (cmd.tgt_idx)
        begin
            tgt_next = idx_reg[IW-1:0];
        end
    end

    // Scan: tag mode walks indexes, dw mode walks the free list.
    logic scan_hit;
    assign scan_hit = scan_tag_mode
        ? (valid_reg[scan_reg] && tag_mem[scan_reg] == blk_reg)
        : dw_reg[scan_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            blk_reg <= in_block[BW-1:0];
            idx_reg <= in_index;
        end
        tgt_reg <= tgt_next;
        if (cmd.scan_start)
        begin
            scan_reg <= scan_tag_mode ? '0 : head_reg;
            left_reg <= scan_tag_mode ? CW'(NUM_BUFFERS) : count_reg;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_tag_mode ? IW'(scan_reg + 1'b1) : nxt_reg[scan_reg];
            left_reg <= left_reg - 1'b1;
        end
        if (cmd.set_tag)
        begin
            tag_mem[tgt_next] <= blk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            busy_reg  <= '0;
            dw_reg    <= '0;
            head_reg  <= '0;
            tail_reg  <= IW'(NUM_BUFFERS - 1);
            count_reg <= CW'(NUM_BUFFERS);
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                nxt_reg[i] <= IW'((i + 1) % NUM_BUFFERS);
                prv_reg[i] <= IW'((i + NUM_BUFFERS - 1) % NUM_BUFFERS);
            end
        end
        else
        begin
            if (cmd.set_busy) busy_reg[tgt_next] <= 1'b1;
            if (cmd.clr_busy) busy_reg[tgt_next] <= 1'b0;
            if (cmd.set_dw)   dw_reg[tgt_next]   <= 1'b1;
            if (cmd.clr_dw)   dw_reg[tgt_next]   <= 1'b0;
            if (cmd.set_tag)  valid_reg[tgt_next] <= 1'b1;
            if (cmd.do_remove && count_reg != '0)
            begin
                if (tgt_next == head_reg)
                    head_reg <= nxt_reg[tgt_next];
                else
                    nxt_reg[prv_reg[tgt_next]] <= nxt_reg[tgt_next];
                if (tgt_next == tail_reg)
                    tail_reg <= prv_reg[tgt_next];
                else
                    prv_reg[nxt_reg[tgt_next]] <= prv_reg[tgt_next];
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.do_append)
            begin
                if (count_reg == '0)
                begin
                    head_reg <= tgt_next;
                end
                else
                begin
                    nxt_reg[tail_reg] <= tgt_next;
                    prv_reg[tgt_next] <= tail_reg;
                end
                tail_reg  <= tgt_next;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign stat.op         = op_reg;
    assign stat.scan_done  = (left_reg == '0);
    assign stat.scan_hit   = scan_hit;
    assign stat.tgt_busy   = busy_reg[tgt_reg];
    assign stat.tgt_dw     = dw_reg[tgt_reg];
    assign stat.idx_ok     = idx_ok && busy_reg[idx_reg[IW-1:0]];
    assign stat.list_empty = (count_reg == '0);

    assign tgt_index = 4'(tgt_reg);
    assign tgt_block = 24'(tag_mem[tgt_reg]);
endmodule

>>> hw/rtl/bbc_ctrl.sv
// Controller state machine sequencing each operation.
module bbc_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bbc_pkg::STATUS_BITS-1:0] out_status,
    output logic                            out_use_tgt,
    output logic                            out_last,
    output bbc_pkg::bbc_cmd_t               cmd,
    output logic                            scan_tag_mode,
    input  bbc_pkg::bbc_stat_t              stat
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_TSCAN  = 4'd2;
    localparam logic [3:0] S_HIT    = 4'd3;
    localparam logic [3:0] S_MISS   = 4'd4;
    localparam logic [3:0] S_MISSWB = 4'd5;
    localparam logic [3:0] S_FSTART = 4'd6;
    localparam logic [3:0] S_FSCAN  = 4'd7;
    localparam logic [3:0] S_FWB    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_WB3    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [3:0] after_reg, after_next;   // state to resume after output
    logic [4:0] wb_cnt_reg, wb_cnt_next; // flush writeback count, max 16
    logic       ov_reg, ov_next;
    logic [2:0] st_reg, st_next;
    logic       ut_reg, ut_next, last_reg, last_next;
    logic       mode_reg, mode_next;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = ov_reg;
    assign out_status    = st_reg;
    assign out_use_tgt   = ut_reg;
    assign out_last      = last_reg;
    assign scan_tag_mode = mode_next;

    always_comb
    begin
        state_next  = state_reg;
        after_next  = after_reg;
        wb_cnt_next = wb_cnt_reg;
        ov_next     = ov_reg;
        st_next     = st_reg;
        ut_next     = ut_reg;
        last_next   = last_reg;
        mode_next   = mode_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.op)
                    bbc_pkg::OP_GET:
                    begin
                        mode_next      = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = S_TSCAN;
                    end
                    bbc_pkg::OP_RELEASE, bbc_pkg::OP_DELAYED, bbc_pkg::OP_WRITE:
                    begin
                        cmd.tgt_idx = 1'b1;
                        if (!stat.idx_ok)
                        begin
                            {ov_next, st_next, ut_next, last_next} =
                                {1'b1, bbc_pkg::ST_BAD, 2'b01};
                            after_next = S_IDLE;
                            state_next = S_OUT;
                        end
                        else if (stat.op == bbc_pkg::OP_WRITE)
                        begin
                            {ov_next, st_next, ut_next, last_next} =
                                {1'b1, bbc_pkg::ST_WRITEBACK, 2'b10};
                            after_next = S_WB3;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.set_dw    = (stat.op == bbc_pkg::OP_DELAYED);
                            cmd.clr_busy  = 1'b1;
                            cmd.do_append = 1'b1;
                            {ov_next, st_next, ut_next, last_next} =
                                {1'b1, bbc_pkg::ST_DONE, 2'b01};
                            after_next = S_IDLE;
                            state_next = S_OUT;
                        end
                    end
                    bbc_pkg::OP_FLUSH:
                    begin
                        wb_cnt_next = '0;
                        state_next  = S_FSTART;
                    end
                    default:
                    begin
                        {ov_next, st_next, ut_next, last_next} =
                            {1'b1, bbc_pkg::ST_BAD, 2'b01};
                        after_next = S_IDLE;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_TSCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_MISS;
                end
                else if (stat.scan_hit)
                begin
                    cmd.tgt_scan = 1'b1;
                    state_next   = S_HIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_HIT:
            begin
                if (stat.tgt_busy)
                begin
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_RETRY, 2'b01};
                end
                else
                begin
                    cmd.do_remove = 1'b1;
                    cmd.set_busy  = 1'b1;
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_HIT, 2'b11};
                end
                after_next = S_IDLE;
                state_next = S_OUT;
            end
            S_MISS:
            begin
                // target the head, check its mark next cycle
                cmd.tgt_head = 1'b1;
                if (stat.list_empty)
                begin
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_NO_FREE, 2'b01};
                    after_next = S_IDLE;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MISSWB;
                end
            end
            S_MISSWB:
            begin
                if (stat.tgt_dw)
                begin
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_WRITEBACK, 2'b10};
                    after_next = S_WB3;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.do_remove = 1'b1;
                    cmd.set_busy  = 1'b1;
                    cmd.clr_dw    = 1'b1;
                    cmd.set_tag   = 1'b1;
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_FILL, 2'b11};
                    after_next = S_IDLE;
                    state_next = S_OUT;
                end
            end
            S_WB3:
            begin
                // writeback has gone out: clear mark, move target to tail
                cmd.clr_dw    = 1'b1;
                cmd.clr_busy  = 1'b1;
                if (stat.op == bbc_pkg::OP_WRITE)
                begin
                    cmd.do_append = 1'b1;
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_DONE, 2'b01};
                    after_next = S_IDLE;
                    state_next = S_OUT;
                end
                else
                begin
                    // on-list entry: unlink now, append on the next pass
                    cmd.do_remove = 1'b1;
                    state_next    = S_FWB;
                end
            end
            S_FWB:
            begin
                cmd.do_append = 1'b1;
                state_next = (stat.op == bbc_pkg::OP_FLUSH) ? S_FSTART : S_MISS;
            end
            S_FSTART:
            begin
                mode_next      = 1'b0;
                cmd.scan_start = 1'b1;
                state_next     = S_FSCAN;
            end
            S_FSCAN:
            begin
                if (stat.scan_done || wb_cnt_reg == 5'(bbc_pkg::NUM_BUFFERS))
                begin
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_DONE, 2'b01};
                    after_next = S_IDLE;
                    state_next = S_OUT;
                end
                else if (stat.scan_hit)
                begin
                    cmd.tgt_scan = 1'b1;
                    wb_cnt_next  = wb_cnt_reg + 1'b1;
                    {ov_next, st_next, ut_next, last_next} =
                        {1'b1, bbc_pkg::ST_WRITEBACK, 2'b10};
                    after_next = S_WB3;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next    = 1'b0;
                    state_next = after_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            after_reg  <= S_IDLE;
            wb_cnt_reg <= '0;
            ov_reg     <= 1'b0;
            st_reg     <= '0;
            ut_reg     <= 1'b0;
            last_reg   <= 1'b0;
            mode_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            after_reg  <= after_next;
            wb_cnt_reg <= wb_cnt_next;
            ov_reg     <= ov_next;
            st_reg     <= st_next;
            ut_reg     <= ut_next;
            last_reg   <= last_next;
            mode_reg   <= mode_next;
        end
    end
endmodule
